[rtl/sorted_priority_queue_assert.svh]
// assertion macros used by the sorted priority queue datapath
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/spq_pkg.sv]
// types and constants of the sorted priority queue
package spq_pkg;

    localparam int ITEM_W = 32;
    localparam int PRIO_W = 16;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_POP    = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_RM_RD,
        S_RM_CMP,
        S_HD_RD,
        S_HD_CAP
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        t_status status;
        logic    ins_issue;
        logic    ins_place;
        logic    ins_shift;
        logic    rm_issue;
        logic    rm_keep;
        logic    rm_finish;
        logic    pop;
        logic    hd_issue;
        logic    hd_capture;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic k_zero;
        logic rd_done;
        logic rd_ge;
        logic rd_eq;
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

[rtl/sorted_priority_queue.sv]
// top level of the sorted priority queue: controller plus datapath around one entry ram
// from accept to result strobe: read head, pop, full insert and empty remove go straight
//   to the head read and capture; insert first takes a read and compare step per entry
//   moved, remove one per entry held; a new item is taken once busy falls with the strobe
// the result strobe lasts one cycle and cannot be held off by the receiver
// synchronous active-low reset empties the queue at once; entry ram contents are not cleared
module sorted_priority_queue import spq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [FUNC_W-1:0]             i_func,
    input  logic signed [ITEM_W-1:0]      i_item_value,
    input  logic [PRIO_W-1:0]             i_priority_req,
    // result channel
    output logic                          o_valid,
    output logic [STAT_W-1:0]             o_status,
    output logic signed [ITEM_W-1:0]      o_head_item,
    output logic [PRIO_W-1:0]             o_head_priority,
    output logic                          o_is_empty,
    output logic [$clog2(CAPACITY+1)-1:0] o_entry_count
);

    // the entries sit in a ring buffer in ram, head at a movable pointer:
    // pop just advances the head, insert walks from the tail toward the head
    // moving each lower-priority entry one slot back, remove compacts the
    // occupied entries in one read/write pass; every item ends with a head read
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_item_value    (i_item_value),
        .i_priority_req  (i_priority_req),
        .o_stat          (dp_stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_head_item     (o_head_item),
        .o_head_priority (o_head_priority),
        .o_is_empty      (o_is_empty),
        .o_entry_count   (o_entry_count)
    );

endmodule

[rtl/spq_ram.sv]
// generic single-write, single-read ram with registered read data
module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/spq_ctrl.sv]
// controller state machine of the sorted priority queue
module spq_ctrl import spq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [FUNC_W-1:0] i_func,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd,
    output logic              o_busy
);

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    case (t_func'(i_func))
                        FUNC_INSERT: begin
                            if (i_stat.full) begin
                                cmd.status = ST_FULL;
                                n_state    = S_HD_RD;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (i_stat.empty) begin
                                cmd.status = ST_EMPTY;
                                n_state    = S_HD_RD;
                            end else begin
                                n_state = S_RM_RD;
                            end
                        end
                        FUNC_POP: begin
                            if (i_stat.empty) begin
                                cmd.status = ST_EMPTY;
                            end else begin
                                cmd.pop = 1'b1;
                            end
                            n_state = S_HD_RD;
                        end
                        default: begin
                            if (i_stat.empty) begin
                                cmd.status = ST_EMPTY;
                            end
                            n_state = S_HD_RD;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (i_stat.k_zero) begin
                    cmd.ins_place = 1'b1;
                    n_state       = S_HD_RD;
                end else begin
                    cmd.ins_issue = 1'b1;
                    n_state       = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_stat.rd_ge) begin
                    cmd.ins_place = 1'b1;
                    n_state       = S_HD_RD;
                end else begin
                    cmd.ins_shift = 1'b1;
                    n_state       = S_INS_RD;
                end
            end
            S_RM_RD: begin
                if (i_stat.rd_done) begin
                    cmd.rm_finish = 1'b1;
                    n_state       = S_HD_RD;
                end else begin
                    cmd.rm_issue = 1'b1;
                    n_state      = S_RM_CMP;
                end
            end
            S_RM_CMP: begin
                cmd.rm_keep = !i_stat.rd_eq;
                n_state     = S_RM_RD;
            end
            S_HD_RD: begin
                cmd.hd_issue = 1'b1;
                n_state      = S_HD_CAP;
            end
            S_HD_CAP: begin
                cmd.hd_capture = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/spq_dp.sv]
// datapath of the sorted priority queue: circular entry store, walk counters, result registers
`include "sorted_priority_queue_assert.svh"

module spq_dp import spq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    input  logic signed [ITEM_W-1:0]      i_item_value,
    input  logic [PRIO_W-1:0]             i_priority_req,
    output t_dp_stat                      o_stat,
    output logic                          o_valid,
    output logic [STAT_W-1:0]             o_status,
    output logic signed [ITEM_W-1:0]      o_head_item,
    output logic [PRIO_W-1:0]             o_head_priority,
    output logic                          o_is_empty,
    output logic [$clog2(CAPACITY+1)-1:0] o_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = ITEM_W + PRIO_W;

    // logical position to physical address, wrapping once around the ring
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [CW-1:0] ofs);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW+1)'(ofs);
        if (sum >= (AW+1)'(CAPACITY)) begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    logic [AW-1:0]            r_head;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_k;
    logic [CW-1:0]            r_rd;
    logic [CW-1:0]            r_wr;
    t_status                  r_status;
    logic                     r_o_valid;
    logic [ITEM_W-1:0]        r_item;
    logic [PRIO_W-1:0]        r_prio;
    logic [ITEM_W-1:0]        r_o_item;
    logic [PRIO_W-1:0]        r_o_prio;
    logic                     r_o_empty;
    logic [CW-1:0]            r_o_count;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [DW-1:0]            wr_data;
    logic [AW-1:0]            rd_addr;
    logic [DW-1:0]            rd_data;
    logic [ITEM_W-1:0]        rd_item;
    logic [PRIO_W-1:0]        rd_prio;

    assign rd_item = rd_data[DW-1:PRIO_W];
    assign rd_prio = rd_data[PRIO_W-1:0];

    always_comb begin
        if (i_cmd.ins_issue) begin
            rd_addr = f_phys(r_head, r_k - CW'(1));
        end else if (i_cmd.rm_issue) begin
            rd_addr = f_phys(r_head, r_rd);
        end else begin
            rd_addr = r_head;
        end
    end

    always_comb begin
        wr_en   = i_cmd.ins_place | i_cmd.ins_shift | i_cmd.rm_keep;
        wr_addr = i_cmd.rm_keep ? f_phys(r_head, r_wr) : f_phys(r_head, r_k);
        wr_data = i_cmd.ins_place ? {r_item, r_prio} : rd_data;
    end

    spq_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_k       <= '0;
            r_rd      <= '0;
            r_wr      <= '0;
            r_status  <= ST_OK;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.hd_capture;
            if (i_cmd.load) begin
                r_k      <= r_count;
                r_rd     <= '0;
                r_wr     <= '0;
                r_status <= i_cmd.status;
            end
            if (i_cmd.pop) begin
                r_head  <= f_phys(r_head, CW'(1));
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.ins_place) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.ins_shift) begin
                r_k <= r_k - CW'(1);
            end
            if (i_cmd.rm_issue) begin
                r_rd <= r_rd + CW'(1);
            end
            if (i_cmd.rm_keep) begin
                r_wr <= r_wr + CW'(1);
            end
            if (i_cmd.rm_finish) begin
                r_count  <= r_wr;
                r_status <= (r_wr == r_count) ? ST_NOMATCH : ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item_value;
            r_prio <= i_priority_req;
        end
        if (i_cmd.hd_capture) begin
            r_o_empty <= (r_count == '0);
            r_o_count <= r_count;
            r_o_item  <= (r_count == '0) ? '0 : rd_item;
            r_o_prio  <= (r_count == '0) ? '0 : rd_prio;
        end
    end

    assign o_stat.k_zero  = (r_k == '0);
    assign o_stat.rd_done = (r_rd == r_count);
    assign o_stat.rd_ge   = (rd_prio >= r_prio);
    assign o_stat.rd_eq   = (rd_prio == r_prio);
    assign o_stat.full    = (r_count == CW'(CAPACITY));
    assign o_stat.empty   = (r_count == '0);

    assign o_valid         = r_o_valid;
    assign o_status        = r_status;
    assign o_head_item     = r_o_item;
    assign o_head_priority = r_o_prio;
    assign o_is_empty      = r_o_empty;
    assign o_entry_count   = r_o_count;

    `SPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `SPQ_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, i_cmd.ins_place, r_count == $past(r_count) + CW'(1), "insert did not add one entry")
    `SPQ_ASSERT_NOW(a_compact_order, i_clk, i_rst_n, i_cmd.rm_finish, r_wr <= r_count, "compaction wrote past read side")
    `SPQ_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, r_o_valid, !r_o_valid, "result strobe held two cycles")
    `SPQ_ASSERT_NEXT(a_head_capture, i_clk, i_rst_n, i_cmd.hd_issue, i_cmd.hd_capture, "head read not followed by capture")

endmodule
